### sv/txcon_pkg.sv
// Shared constants and types for the text console writer.
package txcon_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 16;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CELL_W-1:0] CELL_BLANK   = 16'h0020;
    localparam logic [CELL_W-1:0] CELL_ZERO    = 16'h0000;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCROLL = 6'b000010,
        S_FILL   = 6'b000100,
        S_EXEC   = 6'b001000,
        S_RDWAIT = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

endpackage

### sv/text_console_writer_unit.sv
// Top level of the text console writer: sequencer, cursor and cell store.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per transfer:
//   put a character at the cursor, clear the grid to spaces of one attribute,
//   or read one cell. Each transfer yields exactly one result on the output
//   channel (o_out_valid / i_out_stall): cursor after the operation, the cell
//   word for a read (else 0) and a flag telling whether the grid scrolled.
//   Timing: a put, a no-op or an out-of-range read passes through S_EXEC
//   and S_RESULT, an in-range read also through S_RDWAIT. A clear walks all
//   2000 cells through the single RAM write port. A put with a scroll pending
//   first copies 1920 cells (one RAM read and one write per cycle, pipelined)
//   and blanks the last row. o_in_stall is high whenever the sequencer is busy.
//   Reset: after i_rst_n is released the sequencer clears all 2000 cells to
//   zero, one per cycle, with o_in_stall high; the cursor starts at 0,0.
//   A stalled result holds in the output register; the next item may be
//   accepted meanwhile and waits in its final step until the register frees.
module text_console_writer_unit
    import txcon_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [CHAR_W-1:0] i_attr,
    input  logic [COL_W-1:0]  i_cell_col,
    input  logic [ROW_W-1:0]  i_cell_row,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [COL_W-1:0]  o_cursor_col,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [CELL_W-1:0] o_cell_value,
    output logic              o_scrolled
);

    localparam logic [ADDR_W-1:0] A_COLUMNS   = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] A_LAST_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] A_LAST_CELL = ADDR_W'(CELL_COUNT - 1);
    localparam logic [COL_W-1:0]  C_LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  R_ROWS      = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0]  R_LAST_ROW  = ROW_W'(ROWS - 1);

    t_state              r_state, n_state;
    t_state              r_fill_next, n_fill_next;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [ADDR_W-1:0]   r_wr_addr, n_wr_addr;
    logic [CELL_W-1:0]   r_fill, n_fill;
    logic [COL_W-1:0]    r_cur_col, n_cur_col;
    logic [ROW_W-1:0]    r_cur_row, n_cur_row;
    t_op                 r_op, n_op;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic [CHAR_W-1:0]   r_attr, n_attr;
    logic [COL_W-1:0]    r_rcol, n_rcol;
    logic [ROW_W-1:0]    r_rrow, n_rrow;
    logic [CELL_W-1:0]   r_value, n_value;
    logic                r_scrolled, n_scrolled;
    logic                r_out_valid, n_out_valid;
    logic [COL_W-1:0]    r_out_col, n_out_col;
    logic [ROW_W-1:0]    r_out_row, n_out_row;
    logic [CELL_W-1:0]   r_out_value, n_out_value;
    logic                r_out_scrolled, n_out_scrolled;

    logic                in_xfer;
    logic                out_free;
    logic [ROW_W-1:0]    agen_row;
    logic [COL_W-1:0]    agen_col;
    logic [ADDR_W-1:0]   cell_addr;
    logic                read_ok;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // shared address unit: row * COLUMNS + col
    assign agen_row  = (r_op == OP_READ) ? r_rrow : r_cur_row;
    assign agen_col  = (r_op == OP_READ) ? r_rcol : r_cur_col;
    assign cell_addr = ADDR_W'(agen_row) * A_COLUMNS + ADDR_W'(agen_col);
    assign read_ok   = (r_rcol < COL_W'(COLUMNS)) && (r_rrow < R_ROWS);

    assign ram_raddr = (r_state == S_SCROLL) ? (r_idx + A_COLUMNS) : cell_addr;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cell_addr;
        ram_wdata = {r_attr, r_char};
        case (r_state)
            S_SCROLL: begin
                ram_we    = r_pend;
                ram_waddr = r_wr_addr;
                ram_wdata = ram_rdata;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = r_fill;
            end
            S_EXEC: begin
                ram_we = (r_op == OP_PUT) && (r_char != CHAR_NEWLINE);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state        = r_state;
        n_fill_next    = r_fill_next;
        n_idx          = r_idx;
        n_pend         = r_pend;
        n_wr_addr      = r_wr_addr;
        n_fill         = r_fill;
        n_cur_col      = r_cur_col;
        n_cur_row      = r_cur_row;
        n_op           = r_op;
        n_char         = r_char;
        n_attr         = r_attr;
        n_rcol         = r_rcol;
        n_rrow         = r_rrow;
        n_value        = r_value;
        n_scrolled     = r_scrolled;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_out_value    = r_out_value;
        n_out_scrolled = r_out_scrolled;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op       = t_op'(i_op);
                    n_char     = i_char_code;
                    n_attr     = i_attr;
                    n_rcol     = i_cell_col;
                    n_rrow     = i_cell_row;
                    n_value    = CELL_ZERO;
                    n_scrolled = 1'b0;
                    n_idx      = '0;
                    n_pend     = 1'b0;
                    case (t_op'(i_op))
                        OP_PUT: begin
                            if (r_cur_row >= R_ROWS) begin
                                n_state    = S_SCROLL;
                                n_scrolled = 1'b1;
                                n_cur_row  = R_LAST_ROW;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                        OP_CLEAR: begin
                            n_state     = S_FILL;
                            n_fill      = {i_attr, CHAR_SPACE};
                            n_fill_next = S_RESULT;
                        end
                        default: begin
                            n_state = S_EXEC;
                        end
                    endcase
                end
            end
            S_SCROLL: begin
                if (r_idx < A_LAST_BASE) begin
                    n_pend    = 1'b1;
                    n_wr_addr = r_idx;
                    n_idx     = r_idx + ADDR_W'(1);
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_state     = S_FILL;
                    n_fill      = CELL_BLANK;
                    n_fill_next = S_EXEC;
                end
            end
            S_FILL: begin
                if (r_idx == A_LAST_CELL) begin
                    n_idx   = '0;
                    n_state = r_fill_next;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_EXEC: begin
                n_state = S_RESULT;
                case (r_op)
                    OP_PUT: begin
                        if (r_char == CHAR_NEWLINE) begin
                            n_cur_col = '0;
                            n_cur_row = r_cur_row + ROW_W'(1);
                        end else if (r_cur_col == C_LAST_COL) begin
                            n_cur_col = '0;
                            n_cur_row = r_cur_row + ROW_W'(1);
                        end else begin
                            n_cur_col = r_cur_col + COL_W'(1);
                        end
                    end
                    OP_READ: begin
                        if (read_ok) begin
                            n_state = S_RDWAIT;
                        end
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_RDWAIT: begin
                n_value = ram_rdata;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_col      = r_cur_col;
                    n_out_row      = r_cur_row;
                    n_out_value    = r_value;
                    n_out_scrolled = r_scrolled;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_fill_next <= S_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_fill      <= CELL_ZERO;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_op        <= OP_NOP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_next <= n_fill_next;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_fill      <= n_fill;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr      <= n_wr_addr;
        r_char         <= n_char;
        r_attr         <= n_attr;
        r_rcol         <= n_rcol;
        r_rrow         <= n_rrow;
        r_value        <= n_value;
        r_scrolled     <= n_scrolled;
        r_out_col      <= n_out_col;
        r_out_row      <= n_out_row;
        r_out_value    <= n_out_value;
        r_out_scrolled <= n_out_scrolled;
    end

    txcon_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_cell_value = r_out_value;
    assign o_scrolled   = r_out_scrolled;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("cell store written while idle");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_col <= C_LAST_COL)
        else $error("cursor column out of range");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_row <= R_ROWS)
        else $error("cursor row out of range");
    a_put_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_op == OP_PUT) |-> (r_cur_row < R_ROWS))
        else $error("put executed with scroll pending");
    a_scroll_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL) |-> (r_scrolled && r_op == OP_PUT))
        else $error("scroll without put");
`endif

endmodule

### sv/txcon_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module txcon_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
